// File: src/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

	// Line bytes
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;
	localparam logic [7:0] ESC_BAD   = 8'hFF;
	localparam logic [7:0] LONG_FORM = 8'h80;

	localparam logic [15:0] FCS_INIT    = 16'hFFFF;
	localparam logic [15:0] FCS_POLY    = 16'h8408;
	localparam logic [15:0] FCS_RESIDUE = 16'hF0B8;

	// Parser phases
	localparam int PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_HUNT    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_FIRST   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_HEADER  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_TAG     = 4'd3;
	localparam logic [PHASE_W-1:0] PH_LEN     = 4'd4;
	localparam logic [PHASE_W-1:0] PH_LEN_ONE = 4'd5;
	localparam logic [PHASE_W-1:0] PH_LEN_HI  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_LEN_LO  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_BODY    = 4'd8;
	localparam logic [PHASE_W-1:0] PH_END     = 4'd9;

	// Result kinds
	localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
	localparam logic [2:0] KIND_GOOD       = 3'd1;
	localparam logic [2:0] KIND_CHECK_ERR  = 3'd2;
	localparam logic [2:0] KIND_HDR_REJECT = 3'd3;
	localparam logic [2:0] KIND_TAG_REJECT = 3'd4;
	localparam logic [2:0] KIND_NO_END     = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROTO_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_TAG  = 2'd2;

	localparam logic [7:0] CONTROL_RESET  = 8'd19;
	localparam logic [7:0] PROTO_ID_RESET = 8'd193;
	localparam logic [7:0] SEQ_TAG_RESET  = 8'd48;

	typedef struct packed {
		logic [7:0] control;
		logic [7:0] proto_id;
		logic [7:0] seq_tag;
	} pfr_cfg_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [15:0] len;
	} pfr_result_t;

endpackage

// File: src/pfr_fcs16.sv
// ----------------------------------------------------------------------------
// pfr_fcs16
// FCS-16 (reflected 0x8408) update of the running check over one byte.
// ----------------------------------------------------------------------------
module pfr_fcs16 (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ pfr_pkg::FCS_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule

// File: src/pfr_frame_fsm.sv
// ----------------------------------------------------------------------------
// pfr_frame_fsm
// Frame parser state: one step per line byte, unstuffing, header checks,
// length decode, byte count and frame check.
// ----------------------------------------------------------------------------
module pfr_frame_fsm #(
	parameter int HEADER_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic [7:0]           raw,
	input  pfr_pkg::pfr_cfg_t    cfg,
	output pfr_pkg::pfr_result_t res
);

	localparam int HP_W = $clog2(HEADER_BYTES);
	localparam logic [HP_W-1:0] POS_CONTROL  = HP_W'(HEADER_BYTES - 2);
	localparam logic [HP_W-1:0] POS_PROTO_ID = HP_W'(HEADER_BYTES - 1);
	localparam logic [HP_W:0]   POS_LIMIT    = (HP_W+1)'(HEADER_BYTES);

	logic [pfr_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic                        esc_q, esc_d;
	logic [HP_W-1:0]             hpos_q, hpos_d;
	logic                        hok_q, hok_d;
	logic [15:0]                 clen_q, clen_d;
	logic [16:0]                 brem_q, brem_d;
	logic [15:0]                 crc_q, crc_d;

	logic [7:0]  b;
	logic [15:0] crc_next;

	pfr_fcs16 u_fcs (
		.crc      (crc_q),
		.data     (b),
		.crc_next (crc_next)
	);

	// undo escapes: after an escape mark, 0x5E becomes the flag byte, 0x5D the escape byte, anything else 0xFF
	always_comb begin
		b = raw;
		if (esc_q) begin
			if (raw == pfr_pkg::ESC_FLAG) begin
				b = pfr_pkg::FLAG_BYTE;
			end else if (raw == pfr_pkg::ESC_ESC) begin
				b = pfr_pkg::ESC_BYTE;
			end else begin
				b = pfr_pkg::ESC_BAD;
			end
		end
	end

	always_comb begin
		logic [pfr_pkg::PHASE_W-1:0] eph;
		logic                        work;
		logic                        go;
		logic                        hok_n;
		logic [HP_W:0]               hpos_inc;
		logic [15:0]                 clen_new;
		logic [16:0]                 brem_after;

		phase_d = phase_q;
		esc_d   = esc_q;
		hpos_d  = hpos_q;
		hok_d   = hok_q;
		clen_d  = clen_q;
		brem_d  = brem_q;
		crc_d   = crc_q;
		res     = '0;
		eph     = phase_q;
		work    = 1'b0;
		go      = 1'b0;
		hok_n   = hok_q;
		hpos_inc = {1'b0, hpos_q} + (HP_W+1)'(1);
		clen_new = clen_q;
		brem_after = brem_q;

		case (phase_q)
			pfr_pkg::PH_HUNT: begin
				if (raw == pfr_pkg::FLAG_BYTE) begin
					phase_d = pfr_pkg::PH_FIRST;
					esc_d   = 1'b0;
					hpos_d  = HP_W'(1);
					hok_d   = 1'b1;
					clen_d  = '0;
					brem_d  = '0;
					crc_d   = pfr_pkg::FCS_INIT;
				end
			end
			pfr_pkg::PH_END: begin
				phase_d = pfr_pkg::PH_HUNT;
				if (raw != pfr_pkg::FLAG_BYTE) begin
					res.valid = 1'b1;
					res.kind  = pfr_pkg::KIND_NO_END;
				end
			end
			pfr_pkg::PH_FIRST: begin
				// skip one repeated opening flag
				phase_d = pfr_pkg::PH_HEADER;
				eph     = pfr_pkg::PH_HEADER;
				work    = (raw != pfr_pkg::FLAG_BYTE);
			end
			default: begin
				work = 1'b1;
			end
		endcase

		// track escape marks
		if (work) begin
			if (esc_q) begin
				esc_d = 1'b0;
				go    = 1'b1;
			end else if (raw == pfr_pkg::ESC_BYTE) begin
				esc_d = 1'b1;
			end else begin
				go = 1'b1;
			end
		end

		if (go) begin
			crc_d = crc_next;
			case (eph)
				pfr_pkg::PH_HEADER: begin
					if (hpos_q == POS_CONTROL && b != cfg.control) begin
						hok_n = 1'b0;
					end
					if (hpos_q == POS_PROTO_ID && b != cfg.proto_id) begin
						hok_n = 1'b0;
					end
					hok_d = hok_n;
					if (hpos_inc >= POS_LIMIT) begin
						hpos_d = '0;
						if (!hok_n) begin
							phase_d   = pfr_pkg::PH_HUNT;
							res.valid = 1'b1;
							res.kind  = pfr_pkg::KIND_HDR_REJECT;
						end else begin
							phase_d = pfr_pkg::PH_TAG;
						end
					end else begin
						hpos_d = hpos_inc[HP_W-1:0];
					end
				end
				pfr_pkg::PH_TAG: begin
					res.valid = 1'b1;
					if (b != cfg.seq_tag) begin
						phase_d  = pfr_pkg::PH_HUNT;
						res.kind = pfr_pkg::KIND_TAG_REJECT;
					end else begin
						phase_d  = pfr_pkg::PH_LEN;
						res.kind = pfr_pkg::KIND_PAYLOAD;
						res.data = b;
					end
				end
				pfr_pkg::PH_LEN: begin
					res.valid = 1'b1;
					res.kind  = pfr_pkg::KIND_PAYLOAD;
					res.data  = b;
					if ((b & pfr_pkg::LONG_FORM) == 8'h00) begin
						clen_d  = {8'h00, b};
						brem_d  = {9'h000, b} + 17'd2;
						phase_d = pfr_pkg::PH_BODY;
					end else if (b[0]) begin
						phase_d = pfr_pkg::PH_LEN_ONE;
					end else if (b[1]) begin
						phase_d = pfr_pkg::PH_LEN_HI;
					end else begin
						clen_d  = '0;
						brem_d  = 17'd2;
						phase_d = pfr_pkg::PH_BODY;
					end
				end
				pfr_pkg::PH_LEN_ONE: begin
					res.valid = 1'b1;
					res.kind  = pfr_pkg::KIND_PAYLOAD;
					res.data  = b;
					clen_d    = {8'h00, b};
					brem_d    = {9'h000, b} + 17'd2;
					phase_d   = pfr_pkg::PH_BODY;
				end
				pfr_pkg::PH_LEN_HI: begin
					res.valid = 1'b1;
					res.kind  = pfr_pkg::KIND_PAYLOAD;
					res.data  = b;
					clen_d    = {b, 8'h00};
					phase_d   = pfr_pkg::PH_LEN_LO;
				end
				pfr_pkg::PH_LEN_LO: begin
					res.valid = 1'b1;
					res.kind  = pfr_pkg::KIND_PAYLOAD;
					res.data  = b;
					clen_new  = clen_q | {8'h00, b};
					clen_d    = clen_new;
					brem_d    = {1'b0, clen_new} + 17'd2;
					phase_d   = pfr_pkg::PH_BODY;
				end
				pfr_pkg::PH_BODY: begin
					if (brem_q > 17'd2) begin
						brem_d    = brem_q - 17'd1;
						res.valid = 1'b1;
						res.kind  = pfr_pkg::KIND_PAYLOAD;
						res.data  = b;
					end else begin
						if (brem_q != 17'd0) begin
							brem_after = brem_q - 17'd1;
						end
						brem_d = brem_after;
						if (brem_after == 17'd0) begin
							// judge the frame on the check including both FCS bytes
							phase_d   = pfr_pkg::PH_END;
							res.valid = 1'b1;
							res.kind  = (crc_next == pfr_pkg::FCS_RESIDUE) ?
								pfr_pkg::KIND_GOOD : pfr_pkg::KIND_CHECK_ERR;
							res.len   = clen_q;
						end
					end
				end
				default: begin
					phase_d = pfr_pkg::PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pfr_pkg::PH_HUNT;
			esc_q   <= 1'b0;
			hpos_q  <= '0;
			hok_q   <= 1'b1;
			clen_q  <= '0;
			brem_q  <= '0;
			crc_q   <= pfr_pkg::FCS_INIT;
		end else if (step_en) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			hpos_q  <= hpos_d;
			hok_q   <= hok_d;
			clen_q  <= clen_d;
			brem_q  <= brem_d;
			crc_q   <= crc_d;
		end
	end

endmodule

// File: src/pmpp_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// pmpp_frame_receiver_core
// Byte-stuffed flag-delimited frame receiver with FCS-16 check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall / rx_byte) takes one raw line byte
//   per transaction. Output channel (result_valid / result_stall) carries one
//   result per transaction: kind, data_byte and message_length.
//   A byte that yields no result (flags, escape marks, header bytes of an
//   accepted header, the first FCS byte) produces no output transaction.
//   An accepted byte is held in the input register; the parser result for it
//   moves into the result register once that register is free.
//   Throughput: one byte per cycle while no stalled result waits; the parser
//   step and the FCS-16 byte update sit combinationally between the input
//   and result registers.
//   Stall: when result_stall holds a waiting result, the input register
//   holds its byte and byte_stall rises; at most two bytes stay in flight.
//   Reset: arst_n clears the parser to flag hunting, empties both registers
//   and loads the match registers with their defaults (0x13, 0xC1, 0x30).
//   Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at
//   the next edge; write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module pmpp_frame_receiver_core #(
	parameter int HEADER_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,

	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] message_length
);

	pfr_pkg::pfr_cfg_t    cfg_q;
	pfr_pkg::pfr_result_t res;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  data_q;
	logic [15:0] len_q;
	logic        out_free;
	logic        step;

	// match registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control  <= pfr_pkg::CONTROL_RESET;
			cfg_q.proto_id <= pfr_pkg::PROTO_ID_RESET;
			cfg_q.seq_tag  <= pfr_pkg::SEQ_TAG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pfr_pkg::REG_CONTROL:  cfg_q.control  <= cfg_wdata;
				pfr_pkg::REG_PROTO_ID: cfg_q.proto_id <= cfg_wdata;
				pfr_pkg::REG_SEQ_TAG:  cfg_q.seq_tag  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The parser steps the held byte whenever the result register can take
	// whatever it produces.
	assign out_free   = !out_valid_q || !result_stall;
	assign step       = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	pfr_frame_fsm #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step),
		.raw     (byte_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			kind_q <= res.kind;
			data_q <= res.data;
			len_q  <= res.len;
		end
	end

	assign result_valid   = out_valid_q;
	assign kind           = kind_q;
	assign data_byte      = data_q;
	assign message_length = len_q;

endmodule

// File: src/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks on the frame receiver, attached by bind.
// ----------------------------------------------------------------------------
module pfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [2:0]  kind,
	input logic [7:0]  data_byte,
	input logic [15:0] message_length
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind) &&
		$stable(data_byte) && $stable(message_length))
		else $error("stalled result changed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> kind <= pfr_pkg::KIND_NO_END)
		else $error("result kind out of range");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != pfr_pkg::KIND_PAYLOAD |-> data_byte == 8'h00)
		else $error("data byte set on a status result");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != pfr_pkg::KIND_GOOD && kind != pfr_pkg::KIND_CHECK_ERR
		|-> message_length == 16'h0000)
		else $error("length set outside a frame verdict");

endmodule

bind pmpp_frame_receiver_core pfr_checker u_pfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.kind           (kind),
	.data_byte      (data_byte),
	.message_length (message_length)
);
